// ===== hdl/assert_macros.svh =====
// Assertion macros for the block's top-level RTL file.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define BCES_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define BCES_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define BCES_ASSERT(label, clk, rst, prop, msg)
`define BCES_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ===== hdl/bces_pkg.sv =====
// Package for the color endpoint search: widths, codes, sequencer states.
// Holds the squared-distance helper shared by the top level. No dependencies.
package bces_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SUM_W      = 18;
  localparam int ROOT_W     = 9;
  localparam int THR_W      = 2 * (ROOT_W + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int DIM_RESET  = 4;
  localparam int CHANNELS   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_WIDTH  = 1'b0,
    REG_BLOCK_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_B,
    ST_LATCH_B,
    ST_SCAN,
    ST_ROOT,
    ST_THRESH,
    ST_READ_END,
    ST_LATCH_END,
    ST_LATCH_A,
    ST_MAG_B,
    ST_MAG_A
  } state_t;

  function automatic logic [SUM_W-1:0] sumsq(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q);
    logic [CH_W-1:0]   x;
    logic [CH_W-1:0]   y;
    logic [CH_W-1:0]   d;
    logic [2*CH_W-1:0] sq;
    logic [SUM_W-1:0]  acc;
    acc = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      x   = p[CH_W*c +: CH_W];
      y   = q[CH_W*c +: CH_W];
      d   = (x > y) ? (x - y) : (y - x);
      sq  = (2*CH_W)'(d) * (2*CH_W)'(d);
      acc = acc + SUM_W'(sq);
    end
    return acc;
  endfunction

endpackage

// ===== hdl/bces_if.sv =====
// Channel interfaces of the color endpoint search: pixel in, endpoints out, config.
// Depends on bces_pkg for payload widths.
interface bces_pixel_if import bces_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface bces_endpoint_if import bces_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] low_red;
  logic [CH_W-1:0] low_green;
  logic [CH_W-1:0] low_blue;
  logic [CH_W-1:0] high_red;
  logic [CH_W-1:0] high_green;
  logic [CH_W-1:0] high_blue;

  modport source (output valid, low_red, low_green, low_blue,
                  high_red, high_green, high_blue, input ready);
  modport sink   (input valid, low_red, low_green, low_blue,
                  high_red, high_green, high_blue, output ready);
endinterface

interface bces_cfg_if import bces_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bces_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bces_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bces_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on bces_pkg for operand and root widths.
module bces_isqrt import bces_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  operand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic [SUM_W-1:0] rem;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] bitm;
  logic [SUM_W:0]   trial;
  logic             fits;

  assign trial = {1'b0, acc} + {1'b0, bitm};
  assign fits  = ({1'b0, rem} >= trial);
  assign root  = acc[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (bitm[SUM_W-1:1] == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= operand;
      acc  <= '0;
      bitm <= SUM_W'(1) << (SUM_W - 2);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - trial[SUM_W-1:0];
        acc <= (acc >> 1) + bitm;
      end else begin
        acc <= acc >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

// ===== hdl/block_color_endpoint_search.sv =====
// Block color endpoint search. Pixels are accepted one per cycle in raster order and written
// to an on-chip store; after the last pixel of a block (width x height, each
// clamped to 1..MAX_BLOCK_DIM) the block stops taking pixels and scans every ordered pair
// through one read port of the store, one pair per cycle while no root is pending.
// Each time a strictly longer pair is found the shared square-root unit recomputes the best
// length, pausing the scan. The two endpoints are then ordered by magnitude through the same
// unit. The result waits in an output register; the store needs no clearing after reset.
// Depends on bces_pkg, bces_if, bces_ram, bces_isqrt and assert_macros.svh.
`include "assert_macros.svh"

module block_color_endpoint_search import bces_pkg::*; #(
  parameter int MAX_BLOCK_DIM = 8
) (
  input  logic            clk,
  input  logic            rst,
  bces_pixel_if.sink      pixel,
  bces_cfg_if.sink        cfg,
  bces_endpoint_if.source endpoint
);

  localparam int DEPTH = MAX_BLOCK_DIM * MAX_BLOCK_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = $clog2(MAX_BLOCK_DIM + 1);

  function automatic logic [DW-1:0] dim_clamp(logic [CFG_DATA_W-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) begin
      r = DW'(1);
    end else if (int'(d) > MAX_BLOCK_DIM) begin
      r = DW'(MAX_BLOCK_DIM);
    end else begin
      r = DW'(d);
    end
    return r;
  endfunction

  state_t                state, state_next;
  logic [CFG_DATA_W-1:0] width_cfg;
  logic [CFG_DATA_W-1:0] height_cfg;
  logic [CW-1:0]         cnt, cnt_next;
  logic [CW-1:0]         total_r, total_next;
  logic [CW-1:0]         b_idx, b_next;
  logic [CW-1:0]         a_idx, a_next;
  logic                  v1, v1_next;
  logic                  v2, v2_next;
  logic [CW-1:0]         a1, a1_next;
  logic [CW-1:0]         a2, a2_next;
  logic [SUM_W-1:0]      sum2, sum2_next;
  logic [PIX_W-1:0]      pix_b, pixb_next;
  logic [PIX_W-1:0]      pix_a, pixa_next;
  logic [ROOT_W-1:0]     best_len, blen_next;
  logic [AW-1:0]         best_b, bb_next;
  logic [AW-1:0]         best_a, ba_next;
  logic [THR_W-1:0]      thresh, thr_next;
  logic [ROOT_W-1:0]     mag_b, magb_next;
  logic [PIX_W-1:0]      out_lo, lo_next;
  logic [PIX_W-1:0]      out_hi, hi_next;
  logic                  out_valid;
  logic                  out_load;

  logic [DW-1:0]         wdim;
  logic [DW-1:0]         hdim;
  logic [2*DW-1:0]       area;
  logic [CW-1:0]         total_now;
  logic [CW-1:0]         cnt_inc;
  logic [ROOT_W:0]       len_inc;
  logic [THR_W-1:0]      thr_sq;
  logic                  hit;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [PIX_W-1:0]      ram_rdata;
  logic                  sq_start;
  logic [SUM_W-1:0]      sq_operand;
  logic                  sq_busy;
  logic [ROOT_W-1:0]     sq_root;

  bces_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata ({pixel.blue, pixel.green, pixel.red}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bces_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_operand),
    .busy    (sq_busy),
    .root    (sq_root)
  );

  assign wdim      = dim_clamp(width_cfg);
  assign hdim      = dim_clamp(height_cfg);
  assign area      = {{DW{1'b0}}, wdim} * {{DW{1'b0}}, hdim};
  assign total_now = CW'(area);
  assign cnt_inc   = cnt + CW'(1);
  assign len_inc   = {1'b0, best_len} + (ROOT_W + 1)'(1);
  assign thr_sq    = THR_W'(len_inc) * THR_W'(len_inc);
  assign hit       = v2 && ({{(THR_W - SUM_W){1'b0}}, sum2} >= thresh);

  assign pixel.ready         = (state == ST_IDLE);
  assign cfg.ready           = 1'b1;
  assign endpoint.valid      = out_valid;
  assign endpoint.low_red    = out_lo[CH_W-1:0];
  assign endpoint.low_green  = out_lo[2*CH_W-1:CH_W];
  assign endpoint.low_blue   = out_lo[3*CH_W-1:2*CH_W];
  assign endpoint.high_red   = out_hi[CH_W-1:0];
  assign endpoint.high_green = out_hi[2*CH_W-1:CH_W];
  assign endpoint.high_blue  = out_hi[3*CH_W-1:2*CH_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= CFG_DATA_W'(DIM_RESET);
      height_cfg <= CFG_DATA_W'(DIM_RESET);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_BLOCK_WIDTH:  width_cfg  <= cfg.data;
        REG_BLOCK_HEIGHT: height_cfg <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      v1    <= v1_next;
      v2    <= v2_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (endpoint.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r  <= total_next;
    b_idx    <= b_next;
    a_idx    <= a_next;
    a1       <= a1_next;
    a2       <= a2_next;
    sum2     <= sum2_next;
    pix_b    <= pixb_next;
    pix_a    <= pixa_next;
    best_len <= blen_next;
    best_b   <= bb_next;
    best_a   <= ba_next;
    thresh   <= thr_next;
    mag_b    <= magb_next;
    out_lo   <= lo_next;
    out_hi   <= hi_next;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    total_next = total_r;
    b_next     = b_idx;
    a_next     = a_idx;
    v1_next    = 1'b0;
    v2_next    = 1'b0;
    a1_next    = a1;
    a2_next    = a2;
    sum2_next  = sum2;
    pixb_next  = pix_b;
    pixa_next  = pix_a;
    blen_next  = best_len;
    bb_next    = best_b;
    ba_next    = best_a;
    thr_next   = thresh;
    magb_next  = mag_b;
    lo_next    = out_lo;
    hi_next    = out_hi;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = a_idx[AW-1:0];
    sq_start   = 1'b0;
    sq_operand = sum2;

    case (state)
      ST_IDLE: begin
        if (pixel.valid) begin
          ram_we = 1'b1;
          if (cnt_inc >= total_now) begin
            cnt_next   = '0;
            total_next = total_now;
            b_next     = '0;
            blen_next  = '0;
            bb_next    = '0;
            ba_next    = '0;
            thr_next   = THR_W'(1);
            state_next = ST_READ_B;
          end else begin
            cnt_next = cnt_inc;
          end
        end
      end
      ST_READ_B: begin
        ram_raddr  = b_idx[AW-1:0];
        state_next = ST_LATCH_B;
      end
      ST_LATCH_B: begin
        pixb_next  = ram_rdata;
        a_next     = '0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (a_idx != total_r) begin
          v1_next = 1'b1;
          a1_next = a_idx;
          a_next  = a_idx + CW'(1);
        end
        v2_next   = v1;
        a2_next   = a1;
        sum2_next = sumsq(ram_rdata, pix_b);
        if (hit) begin
          // flush the pipe and restart after the pair just taken
          v1_next    = 1'b0;
          v2_next    = 1'b0;
          a_next     = a2 + CW'(1);
          bb_next    = b_idx[AW-1:0];
          ba_next    = a2[AW-1:0];
          sq_start   = 1'b1;
          sq_operand = sum2;
          state_next = ST_ROOT;
        end else if ((a_idx == total_r) && !v1 && !v2) begin
          if ((b_idx + CW'(1)) == total_r) begin
            state_next = ST_READ_END;
          end else begin
            b_next     = b_idx + CW'(1);
            state_next = ST_READ_B;
          end
        end
      end
      ST_ROOT: begin
        if (!sq_busy) begin
          blen_next  = sq_root;
          state_next = ST_THRESH;
        end
      end
      ST_THRESH: begin
        thr_next   = thr_sq;
        state_next = ST_SCAN;
      end
      ST_READ_END: begin
        ram_raddr  = best_b;
        state_next = ST_LATCH_END;
      end
      ST_LATCH_END: begin
        pixb_next  = ram_rdata;
        ram_raddr  = best_a;
        state_next = ST_LATCH_A;
      end
      ST_LATCH_A: begin
        pixa_next  = ram_rdata;
        sq_start   = 1'b1;
        sq_operand = sumsq(pix_b, PIX_W'(0));
        state_next = ST_MAG_B;
      end
      ST_MAG_B: begin
        if (!sq_busy) begin
          magb_next  = sq_root;
          sq_start   = 1'b1;
          sq_operand = sumsq(pix_a, PIX_W'(0));
          state_next = ST_MAG_A;
        end
      end
      ST_MAG_A: begin
        if (!sq_busy && (!out_valid || endpoint.ready)) begin
          out_load = 1'b1;
          if (sq_root > mag_b) begin
            lo_next = pix_b;
            hi_next = pix_a;
          end else begin
            lo_next = pix_a;
            hi_next = pix_b;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `BCES_NEVER(a_idle_root_free, clk, rst, (state == ST_IDLE) && sq_busy,
              "root unit busy while idle")
  `BCES_ASSERT(a_thresh_grows, clk, rst,
               (state == ST_THRESH) |=> (thresh > $past(thresh)),
               "best length did not grow")
  `BCES_ASSERT(a_best_in_block, clk, rst,
               (state == ST_SCAN) |-> ((CW'(best_b) < total_r) && (CW'(best_a) < total_r)),
               "best pair outside block")
  `BCES_ASSERT(a_count_in_store, clk, rst, (state == ST_IDLE) |-> (int'(cnt) < DEPTH),
               "load count past store")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for block_color_endpoint_search: streams pixel blocks of many
// shapes, predicts each block's endpoint pair in-line and checks every result word.
// Depends on bces_pkg, the bces_if interfaces and the block's RTL.
module tb_top;
  import bces_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_DIM      = 8;
  localparam int          STORE_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int          PHASE_ITEMS  = 400;
  localparam int          HOLD_CYCLES  = 1500;
  localparam int          SETTLE_PAUSE = 20;
  localparam int          TAIL_PAUSE   = 500;
  localparam int unsigned CYCLE_LIMIT  = 3000000;

  typedef struct packed {
    logic [CH_W-1:0] low_red;
    logic [CH_W-1:0] low_green;
    logic [CH_W-1:0] low_blue;
    logic [CH_W-1:0] high_red;
    logic [CH_W-1:0] high_green;
    logic [CH_W-1:0] high_blue;
  } endpoint_t;

  typedef enum int {
    STYLE_FLAT,
    STYLE_TWO_TONE,
    STYLE_CORNERS,
    STYLE_CLUSTER,
    STYLE_NOISE
  } block_style_t;

  logic clk;
  logic rst;

  bces_pixel_if    pixel_ch();
  bces_cfg_if      cfg_ch();
  bces_endpoint_if endpoint_ch();

  block_color_endpoint_search #(.MAX_BLOCK_DIM(MAX_DIM)) DUT (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel_ch),
    .cfg      (cfg_ch),
    .endpoint (endpoint_ch)
  );

  logic [PIX_W-1:0]      pixel_q[$];
  endpoint_t             pending_endpoints[$];
  logic [PIX_W-1:0]      pixel_mem [STORE_DEPTH];
  logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(DIM_RESET);
  logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(DIM_RESET);
  int unsigned           fill_level = 0;
  int unsigned           queued_count = 0;
  int unsigned           sent_count = 0;
  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;
  logic                  hold_active = 1'b0;
  logic [PIX_W-1:0]      staged_pixel;
  endpoint_t             seen_pair;
  endpoint_t             wanted_pair;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("block_color_endpoint_search verification failed");
      $finish;
    end
  end

  function automatic int unsigned effective_dim(logic [CFG_DATA_W-1:0] d);
    int unsigned v;
    v = 32'(d);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned floor_root(int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 9; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic int unsigned squared_gap(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q);
    int unsigned acc;
    int unsigned x;
    int unsigned y;
    int unsigned d;
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      x = 32'(p[CH_W*c +: CH_W]);
      y = 32'(q[CH_W*c +: CH_W]);
      d = (x > y) ? x - y : y - x;
      acc += d * d;
    end
    return acc;
  endfunction

  // Store one pixel; on the last pixel of a block, search the widest pair and order it.
  function automatic void load_pixel(logic [PIX_W-1:0] px);
    int unsigned total;
    int unsigned best;
    int unsigned len;
    int unsigned outer;
    int unsigned inner;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    endpoint_t want;
    total = effective_dim(width_reg) * effective_dim(height_reg);
    if (fill_level < STORE_DEPTH) pixel_mem[fill_level] = px;
    fill_level = (fill_level + 1) & 32'h7F;
    if (fill_level < total) return;
    fill_level = 0;
    best = 0;
    outer = 0;
    inner = 0;
    for (int unsigned b = 0; b < total; b++) begin
      for (int unsigned a = 0; a < total; a++) begin
        if (a != b) begin
          len = floor_root(squared_gap(pixel_mem[a], pixel_mem[b]));
          if (len > best) begin
            best = len;
            outer = b;
            inner = a;
          end
        end
      end
    end
    if (floor_root(squared_gap(pixel_mem[inner], '0)) >
        floor_root(squared_gap(pixel_mem[outer], '0))) begin
      lo = pixel_mem[outer];
      hi = pixel_mem[inner];
    end else begin
      lo = pixel_mem[inner];
      hi = pixel_mem[outer];
    end
    want.low_red    = lo[7:0];
    want.low_green  = lo[15:8];
    want.low_blue   = lo[23:16];
    want.high_red   = hi[7:0];
    want.high_green = hi[15:8];
    want.high_blue  = hi[23:16];
    pending_endpoints.push_back(want);
  endfunction

  function automatic void compare_channel(string name, logic [CH_W-1:0] want,
                                          logic [CH_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t %s mismatch: expected %h actual %h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : pixel_driver
    if (rst) begin
      pixel_ch.valid <= 1'b0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        load_pixel({pixel_ch.blue, pixel_ch.green, pixel_ch.red});
        sent_count++;
      end
      if (!pixel_ch.valid || pixel_ch.ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          staged_pixel = pixel_q.pop_front();
          pixel_ch.red   <= staged_pixel[7:0];
          pixel_ch.green <= staged_pixel[15:8];
          pixel_ch.blue  <= staged_pixel[23:16];
          pixel_ch.valid <= 1'b1;
        end else begin
          pixel_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : endpoint_monitor
    if (rst) begin
      endpoint_ch.ready <= 1'b0;
    end else begin
      if (endpoint_ch.valid && endpoint_ch.ready) begin
        seen_pair.low_red    = endpoint_ch.low_red;
        seen_pair.low_green  = endpoint_ch.low_green;
        seen_pair.low_blue   = endpoint_ch.low_blue;
        seen_pair.high_red   = endpoint_ch.high_red;
        seen_pair.high_green = endpoint_ch.high_green;
        seen_pair.high_blue  = endpoint_ch.high_blue;
        if (pending_endpoints.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t unexpected endpoint word %h", $realtime, seen_pair);
        end else begin
          wanted_pair = pending_endpoints.pop_front();
          compare_channel("low_red",    wanted_pair.low_red,    seen_pair.low_red);
          compare_channel("low_green",  wanted_pair.low_green,  seen_pair.low_green);
          compare_channel("low_blue",   wanted_pair.low_blue,   seen_pair.low_blue);
          compare_channel("high_red",   wanted_pair.high_red,   seen_pair.high_red);
          compare_channel("high_green", wanted_pair.high_green, seen_pair.high_green);
          compare_channel("high_blue",  wanted_pair.high_blue,  seen_pair.high_blue);
        end
      end
      endpoint_ch.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_pixel(logic [PIX_W-1:0] px);
    pixel_q.push_back(px);
    queued_count++;
  endtask

  task automatic push_block(int unsigned n);
    int unsigned pick;
    block_style_t style;
    logic [PIX_W-1:0] anchor;
    logic [PIX_W-1:0] other;
    logic [PIX_W-1:0] px;
    pick = $urandom_range(6);
    style = (pick > STYLE_NOISE) ? STYLE_NOISE : block_style_t'(pick);
    anchor = PIX_W'($urandom);
    other = PIX_W'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      case (style)
        STYLE_FLAT: px = anchor;
        STYLE_TWO_TONE: px = $urandom_range(1) ? anchor : other;
        STYLE_CORNERS: px = {($urandom_range(1) ? 8'hFF : 8'h00),
                             ($urandom_range(1) ? 8'hFF : 8'h00),
                             ($urandom_range(1) ? 8'hFF : 8'h00)};
        STYLE_CLUSTER: px = anchor ^ (PIX_W'($urandom) & 24'h070707);
        default: px = PIX_W'($urandom);
      endcase
      push_pixel(px);
    end
  endtask

  // Hold until every pixel is taken and every endpoint word has come back.
  task automatic drain(int unsigned pause);
    while (sent_count != queued_count || pending_endpoints.size() != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_BLOCK_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 14) return CFG_DATA_W'($urandom_range(15, 9));
    if (roll < 18) return CFG_DATA_W'(MAX_DIM);
    return CFG_DATA_W'($urandom_range(4, 1));
  endfunction

  task automatic run_segment(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    int unsigned n;
    int unsigned blocks;
    drain(SETTLE_PAUSE);
    write_reg(REG_BLOCK_WIDTH, w);
    write_reg(REG_BLOCK_HEIGHT, h);
    n = effective_dim(w) * effective_dim(h);
    blocks = (n >= 24) ? 1 : 24 / n;
    repeat (blocks) push_block(n);
    // leave a partial block so the next shape change lands mid-block
    if (n > 1 && $urandom_range(3) == 0) begin
      repeat ($urandom_range(n - 1, 1)) push_pixel(PIX_W'($urandom));
    end
  endtask

  initial begin
    logic [PIX_W-1:0] opening [16];
    int unsigned phase_start;
    pixel_ch.valid    = 1'b0;
    pixel_ch.red      = '0;
    pixel_ch.green    = '0;
    pixel_ch.blue     = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_BLOCK_WIDTH;
    cfg_ch.data       = '0;
    endpoint_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset shape 4x4: extremes, duplicated widest pair
    opening = '{24'h000000, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                24'hFFFFFF, 24'h808080, 24'h7F7F7F, 24'h000000,
                24'hFFFFFF, 24'h010203, 24'hFEFDFC, 24'h55AA55,
                24'hAA55AA, 24'h000001, 24'hFFFFFE, 24'h123456};
    foreach (opening[i]) push_pixel(opening[i]);
    drain(SETTLE_PAUSE);
    write_reg(REG_BLOCK_WIDTH, 4'd0);
    write_reg(REG_BLOCK_HEIGHT, 4'd0);
    push_pixel(24'h3C5AA5);
    drain(SETTLE_PAUSE);
    write_reg(REG_BLOCK_WIDTH, 4'd2);
    write_reg(REG_BLOCK_HEIGHT, 4'd1);
    push_pixel(24'h4B4B4B);
    push_pixel(24'h4B4B4B);
    push_pixel(24'h0000FF);
    push_pixel(24'hFF0000);
    drain(SETTLE_PAUSE);
    write_reg(REG_BLOCK_WIDTH, 4'd15);
    push_pixel(24'h102030);
    push_pixel(24'hE0D0C0);
    push_pixel(24'h405060);
    drain(SETTLE_PAUSE);
    write_reg(REG_BLOCK_WIDTH, 4'd2);
    push_pixel(24'h998877);

    for (int p = 0; p < 4; p++) begin
      drain(SETTLE_PAUSE);
      case (p)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 46;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 46;
        end
        default: begin
          send_idle_pct  <= 12;
          recv_stall_pct <= 12;
        end
      endcase
      phase_start = queued_count;
      case (p)
        0: begin
          // stall the result side long enough to back up the pixel input
          drain(SETTLE_PAUSE);
          write_reg(REG_BLOCK_WIDTH, 4'd2);
          write_reg(REG_BLOCK_HEIGHT, 4'd2);
          hold_active <= 1'b1;
          repeat (12) push_block(4);
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_active <= 1'b0;
        end
        1: run_segment(4'd15, 4'd15);
        2: run_segment(4'd8, 4'd0);
        default: run_segment(4'd0, 4'd9);
      endcase
      while (queued_count - phase_start < PHASE_ITEMS) run_segment(pick_dim(), pick_dim());
    end

    drain(TAIL_PAUSE);
    if (mismatch_count == 0) begin
      $display("block_color_endpoint_search verification clean");
    end else begin
      $display("block_color_endpoint_search verification failed");
    end
    $finish;
  end

endmodule
